[rtl/sorted_priority_queue_assert.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Needs nothing else; the modules that check their own logic include it.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
// Used by spq_ctrl and sorted_priority_queue; depends on nothing.
package spq_pkg;

  localparam int PRIO_W    = 4;
  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = PRIO_W + DATA_W;
  localparam int TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
  localparam int TD_PAD_W  = TDATA_W - ENTRY_W;
  localparam int STATUS_W  = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } result_t;

endpackage

[rtl/spq_ctrl.sv]
// Queue controller: the circular entry memory, head/tail/count and the sequencer.
// Depends on spq_pkg and the assertion macros in sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  spq_pkg::op_t               in_op,
  input  logic [spq_pkg::PRIO_W-1:0] in_prio,
  input  logic [spq_pkg::DATA_W-1:0] in_payload,
  output logic                       res_valid,
  input  logic                       res_ready,
  output spq_pkg::result_t           res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DRD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    wr_pos_r, wr_pos_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  spq_pkg::entry_t  new_r, new_nxt;
  spq_pkg::result_t res_r, res_nxt;

  // Entry memory, one write and one registered read per cycle.
  spq_pkg::entry_t  store_r [QUEUE_DEPTH];
  spq_pkg::entry_t  rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  spq_pkg::entry_t  mem_wdata;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    if (a == AW'(QUEUE_DEPTH - 1)) return '0;
    return a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    if (a == '0) return AW'(QUEUE_DEPTH - 1);
    return a - AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= store_r[mem_raddr];
  end

  // The insertion walk runs from the tail toward the head. Each cycle it writes
  // one slot and reads the slot two below it, so a read never targets a slot
  // that is still waiting to be written and no forwarding is needed.
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    wr_pos_nxt  = wr_pos_r;
    rd_addr_nxt = rd_addr_r;
    rem_nxt     = rem_r;
    new_nxt     = new_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_pos_r;
    mem_wdata   = new_r;
    mem_raddr   = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_op == spq_pkg::OP_ENQ) begin
          mem_raddr = addr_dec(tail_r);
        end
        if (in_valid) begin
          if (in_op == spq_pkg::OP_ENQ) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_nxt   = '{status: spq_pkg::ST_FULL, prio: '0, payload: '0};
              state_nxt = S_DONE;
            end else begin
              wr_pos_nxt  = tail_r;
              rd_addr_nxt = addr_dec(tail_r);
              rem_nxt     = count_r;
              new_nxt     = '{prio: in_prio, payload: in_payload};
              state_nxt   = S_WALK;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt   = '{status: spq_pkg::ST_EMPTY, prio: '0, payload: '0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DRD;
            end
          end
        end
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_raddr = addr_dec(rd_addr_r);
        // Stop behind the first entry that is at least as urgent, which keeps
        // equal priorities in arrival order.
        if (rem_r == '0 || rdata_r.prio <= new_r.prio) begin
          mem_wdata = new_r;
          tail_nxt  = addr_inc(tail_r);
          count_nxt = count_r + CW'(1);
          res_nxt   = '{status: spq_pkg::ST_ENQUEUED, prio: '0, payload: '0};
          state_nxt = S_DONE;
        end else begin
          mem_wdata   = rdata_r;
          wr_pos_nxt  = rd_addr_r;
          rd_addr_nxt = addr_dec(rd_addr_r);
          rem_nxt     = rem_r - CW'(1);
        end
      end
      S_DRD: begin
        res_nxt   = '{status: spq_pkg::ST_DEQUEUED, prio: rdata_r.prio,
                      payload: rdata_r.payload};
        head_nxt  = addr_inc(head_r);
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_pos_r  <= wr_pos_nxt;
    rd_addr_r <= rd_addr_nxt;
    rem_r     <= rem_nxt;
    new_r     <= new_nxt;
    res_r     <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  `SPQ_ASSERT_NOW(a_ptr_count, clk, rst_n, head_r == tail_r,
    count_r == '0 || count_r == CW'(QUEUE_DEPTH), "head equals tail with a partial count")
  `SPQ_ASSERT_NOW(a_walk_bound, clk, rst_n, state_r == S_WALK, rem_r <= count_r,
    "insertion walk runs past the head")
  `SPQ_ASSERT_NOW(a_no_overlap, clk, rst_n, mem_we && rem_r > CW'(1),
    mem_waddr != mem_raddr, "walk reads the slot it writes")
  `SPQ_ASSERT_NEXT(a_count_hold, clk, rst_n, state_r != S_WALK && state_r != S_DRD,
    $stable(count_r), "entry count changed outside an update")

endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: stream ports and the result register.
// Depends on spq_pkg and spq_ctrl.
//
// A bounded priority queue of QUEUE_DEPTH entries. Each input item is either
// an enqueue of a 4-bit priority (0 is most urgent) with a 32-bit payload, or
// a dequeue of the most urgent entry; among equal priorities the oldest entry
// leaves first. Every item yields exactly one result item whose tuser carries
// the status: enqueued, dequeued, queue empty (dequeue on an empty queue) or
// queue full (the new entry is dropped). Only a dequeued result carries a
// priority and payload; all other results carry zeros there. Entries sit in a
// circular single-port-write, registered-read memory kept in priority order,
// so a dequeue only advances the head pointer, while an enqueue walks from the
// tail toward the head moving one larger-priority entry up per cycle. The
// block takes one item at a time. A dequeue reads the head entry and then
// posts its result; a dropped enqueue or empty dequeue posts its result at
// once; an enqueue walks past every stored entry with a larger priority
// value than the new one before it writes the new entry and posts its result.
// A finished result moves into the output register, so the next item is
// accepted while a result is still waiting downstream. The memory needs no
// clearing after reset: only slots between head and tail are ever read.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: priority_req[3:0], payload[35:4], zero pad [39:36].
  input  logic [spq_pkg::TDATA_W-1:0] in_tdata,
  // Fields from bit 0: op[0].
  input  logic [0:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // Fields from bit 0: out_priority[3:0], out_payload[35:4], zero pad [39:36].
  output logic [spq_pkg::TDATA_W-1:0] out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [spq_pkg::STATUS_W-1:0] out_tuser
);

  logic             res_valid;
  logic             res_ready;
  spq_pkg::result_t res;
  spq_pkg::op_t     in_op;

  logic             out_valid_r, out_valid_nxt;
  spq_pkg::result_t out_res_r, out_res_nxt;

  // The tuser bit selects the operation.
  assign in_op = spq_pkg::op_t'(in_tuser[0]);

  spq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_op),
    .in_prio    (in_tdata[spq_pkg::PRIO_W-1:0]),
    .in_payload (in_tdata[spq_pkg::ENTRY_W-1:spq_pkg::PRIO_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // The output register frees the controller as soon as it holds a result,
  // and takes the next one in the same cycle that the current one leaves.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{spq_pkg::TD_PAD_W{1'b0}}, out_res_r.payload, out_res_r.prio};
  assign out_tuser  = out_res_r.status;

endmodule
